@@ rtl/fpcp_pkg.sv @@
// Types and constants shared by the flow packet checksum parser.
package fpcp_pkg;

   localparam int unsigned COUNT_W = 8;
   localparam int unsigned INTERVAL_W = 26;
   localparam int unsigned DT_W = 16;

   localparam logic [7:0]  FLOW_KIND = 8'h01;
   localparam logic [7:0]  MIN_PACKET_BYTES = 8'd26;
   localparam logic [9:0]  MS_TO_US = 10'd1000;
   localparam logic [7:0]  UPWARD_CODE_RESET = 8'd1;
   localparam logic [15:0] MIN_INTERVAL_RESET = 16'd10;
   localparam logic [15:0] MAX_INTERVAL_RESET = 16'd500;

   typedef enum logic [1:0] {
      CSR_UPWARD_CODE  = 2'd0,
      CSR_MIN_INTERVAL = 2'd1,
      CSR_MAX_INTERVAL = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic signed [31:0]      delta_x;
      logic signed [31:0]      delta_y;
      logic signed [31:0]      height;
      logic signed [31:0]      clarity_tenths;
      logic [INTERVAL_W-1:0]   interval_us;
      logic [7:0]              direction_code;
   } rsp_type;

   // accepted message waiting for its stamp difference
   typedef struct packed {
      logic [31:0] word_x;
      logic [31:0] word_y;
      logic [31:0] word_z;
      logic [31:0] word_clarity;
      logic [31:0] word_stamp;
      logic [7:0]  direction;
      logic        slot;
   } pend_type;

endpackage

@@ rtl/flow_packet_checksum_parser.sv @@
// Top level: byte-serial optical-flow message parser with an 8-bit Fletcher (modulo 256) check.
// Throughput: one message byte per cycle; req_ready drops only when the snapshot,
//   difference and output stages all hold a result and the receiver stalls.
// Path: an accepted message is registered in the snapshot, then the stamp
//   difference, then the multiply into the output register that drives rsp_valid.
// Reset: synchronous, active high; clears message state, stamp slots, stage valids.
module flow_packet_checksum_parser #(
   parameter int MAX_PACKET_BYTES = 255
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fpcp_pkg::req_type    req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fpcp_pkg::rsp_type    rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import fpcp_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are always taken; index 3 is dropped.
   // ---------------------------------------------------------------------
   logic [7:0]  upward_code_ff;
   logic [15:0] min_interval_ff;
   logic [15:0] max_interval_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upward_code_ff  <= UPWARD_CODE_RESET;
         min_interval_ff <= MIN_INTERVAL_RESET;
         max_interval_ff <= MAX_INTERVAL_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_UPWARD_CODE:  upward_code_ff  <= csr_wdata[7:0];
            CSR_MIN_INTERVAL: min_interval_ff <= csr_wdata;
            CSR_MAX_INTERVAL: max_interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage valids and flow control. Each stage loads when it is empty or
   // when it hands its content on in the same cycle.
   // ---------------------------------------------------------------------
   logic     s1_valid_ff, s1_valid_in;
   logic     s2_valid_ff, s2_valid_in;
   logic     rsp_valid_ff, rsp_valid_in;
   pend_type s1_data_ff;
   rsp_type  s2_data_ff;
   logic [DT_W-1:0] s2_dt_ff;
   rsp_type  rsp_data_ff;

   logic out_free, s2_free, s1_free;
   logic s1_go, s2_go;
   logic req_take, s1_load;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s2_go     = s2_valid_ff && out_free;
   assign s1_go     = s1_valid_ff && s2_free;
   assign req_ready = s1_free;
   assign req_take  = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // Byte stage: running checksum, two-byte delay line, field capture.
   // The last held byte and the final byte of a message are the checksum.
   // ---------------------------------------------------------------------
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic        overrun_ff, overrun_in;
   logic [7:0]  kind_ff;
   logic [7:0]  direction_ff;
   logic [31:0] word_x_ff, word_y_ff, word_z_ff, word_clarity_ff, word_stamp_ff;
   logic        message_ok;
   logic [7:0]  data_b;
   logic [1:0]  lane;

   assign data_b = req_payload.data_byte;
   assign lane   = byte_count_ff[1:0];

   always_comb begin
      overrun_in    = overrun_ff || (32'(byte_count_ff) >= 32'(MAX_PACKET_BYTES));
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      // the oldest delay-line byte joins the sum once two bytes are held
      if (byte_count_ff >= 8'd2) begin
         sum_a_in = sum_a_ff + held0_ff;
         sum_b_in = sum_b_ff + sum_a_in;
      end
      held0_in      = held1_ff;
      held1_in      = data_b;
      byte_count_in = (byte_count_ff == 8'hFF) ? byte_count_ff : byte_count_ff + 8'd1;
      message_ok    = (kind_ff == FLOW_KIND) && (byte_count_ff >= MIN_PACKET_BYTES - 8'd1)
                      && !overrun_in && (held1_ff == sum_a_in) && (data_b == sum_b_in);
      if (req_payload.last_byte) begin
         // end of message: clear the per-message state whatever the verdict
         byte_count_in = '0;
         sum_a_in      = '0;
         sum_b_in      = '0;
         held0_in      = '0;
         held1_in      = '0;
         overrun_in    = 1'b0;
      end
   end

   assign s1_load = req_take && req_payload.last_byte && message_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         held0_ff      <= '0;
         held1_ff      <= '0;
         overrun_ff    <= 1'b0;
      end else if (req_take) begin
         byte_count_ff <= byte_count_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         held0_ff      <= held0_in;
         held1_ff      <= held1_in;
         overrun_ff    <= overrun_in;
      end
   end

   // field capture by byte offset; words are little endian
   always_ff @(posedge clock) begin
      if (req_take) begin
         case (byte_count_ff) inside
            8'd0:         kind_ff                    <= data_b;
            8'd1:         direction_ff               <= data_b;
            [8'd4:8'd7]:  word_x_ff[8*lane +: 8]     <= data_b;
            [8'd8:8'd11]: word_y_ff[8*lane +: 8]     <= data_b;
            [8'd12:8'd15]: word_z_ff[8*lane +: 8]    <= data_b;
            [8'd16:8'd19]: word_clarity_ff[8*lane +: 8] <= data_b;
            [8'd20:8'd23]: word_stamp_ff[8*lane +: 8] <= data_b;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: snapshot of an accepted message, so the next message can
   // overwrite the capture registers while this one waits.
   // ---------------------------------------------------------------------
   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_free);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff.word_x       <= word_x_ff;
         s1_data_ff.word_y       <= word_y_ff;
         s1_data_ff.word_z       <= word_z_ff;
         s1_data_ff.word_clarity <= word_clarity_ff;
         s1_data_ff.word_stamp   <= word_stamp_ff;
         s1_data_ff.direction    <= direction_ff;
         s1_data_ff.slot         <= (direction_ff == upward_code_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Stamp difference against the slot's previous stamp, gated by the
   // window. The slot records the stamp whether or not the window passes.
   // ---------------------------------------------------------------------
   logic [31:0] prev_stamp_ff [2];
   logic [1:0]  stamp_seen_ff;
   logic [31:0] dt_ms;
   logic        in_window;
   logic [DT_W-1:0] dt_gated;

   assign dt_ms     = s1_data_ff.word_stamp - prev_stamp_ff[s1_data_ff.slot];
   assign in_window = stamp_seen_ff[s1_data_ff.slot]
                      && (dt_ms >= {16'd0, min_interval_ff})
                      && (dt_ms <= {16'd0, max_interval_ff});
   // an in-window difference never exceeds the 16-bit maximum
   assign dt_gated  = in_window ? dt_ms[DT_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_stamp_ff[0] <= '0;
         prev_stamp_ff[1] <= '0;
         stamp_seen_ff    <= '0;
      end else if (s1_go) begin
         prev_stamp_ff[s1_data_ff.slot] <= s1_data_ff.word_stamp;
         stamp_seen_ff[s1_data_ff.slot] <= 1'b1;
      end
   end

   assign s2_valid_in = s1_go || (s2_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s2_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_data_ff.delta_x        <= s1_data_ff.word_x;
         s2_data_ff.delta_y        <= s1_data_ff.word_y;
         s2_data_ff.height         <= s1_data_ff.word_z;
         s2_data_ff.clarity_tenths <= s1_data_ff.word_clarity;
         s2_data_ff.interval_us    <= '0;
         s2_data_ff.direction_code <= s1_data_ff.direction;
         s2_dt_ff                  <= dt_gated;
      end
   end

   // ---------------------------------------------------------------------
   // Output register: milliseconds to microseconds, 16 x 10 multiply.
   // ---------------------------------------------------------------------
   rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in             = s2_data_ff;
      rsp_data_in.interval_us = INTERVAL_W'(s2_dt_ff) * INTERVAL_W'(MS_TO_US);
   end

   assign rsp_valid_in = s2_go || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s2_go) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // two accepted messages never come back to back
   a_no_adjacent_ok: assert property (@(posedge clock) disable iff (reset)
      s1_load |=> !s1_load)
      else $error("two accepted messages on consecutive bytes");

   // the final byte always clears the per-message state
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_payload.last_byte) |=> (byte_count_ff == '0 && !overrun_ff))
      else $error("message state not cleared after final byte");

   // a slot hand-off always marks a stamp as seen
   a_slot_marked: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> (stamp_seen_ff != 2'b00))
      else $error("stamp slot not marked after hand-off");

   // the interval never exceeds the largest 16-bit window scaled to microseconds
   a_interval_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.interval_us <= 26'd65535000))
      else $error("interval beyond the largest window");
`endif

endmodule
